FILE: design/isd_pkg.sv
// Shared types and constants for the IMU sample to servo/LED drive block.
package isd_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_OFFSET  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_OFFSET   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_RANGE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_RANGE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REPORT_PERIOD = 3'd4;

  localparam logic [15:0] REPORT_PERIOD_RST = 16'd100;

  // Serial divider geometry
  localparam int DIV_W     = 36;  // dividend / quotient shift register
  localparam int DIV_CNT_W = 6;   // iteration count, up to DIV_W
  localparam int DIV_DSR_W = 14;  // widest divisor is 13100

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] nbits;
    logic [DIV_DSR_W-1:0] divisor;
    logic [DIV_W-1:0]     dividend;  // left aligned to nbits
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
  } div_rsp_t;

  // Yaw step divisors: 100 * counts per deg/s for each gyro range
  localparam logic [DIV_DSR_W-1:0] GYRO_DIV [4] = '{14'd13100, 14'd6550, 14'd3280, 14'd1640};

  // Divisors of the other divisions, and quotient widths of all five
  localparam logic [DIV_DSR_W-1:0] SERVO_DIV = 14'd21;
  localparam logic [DIV_DSR_W-1:0] LED_DIV   = 14'd25;
  localparam logic [DIV_DSR_W-1:0] VEL_DIV   = 14'd625;
  localparam logic [DIV_DSR_W-1:0] DIST_DIV  = 14'd25;

  localparam logic [DIV_CNT_W-1:0] YAW_BITS   = 6'd36;
  localparam logic [DIV_CNT_W-1:0] SERVO_BITS = 6'd16;
  localparam logic [DIV_CNT_W-1:0] LED_BITS   = 6'd13;
  localparam logic [DIV_CNT_W-1:0] VEL_BITS   = 6'd27;
  localparam logic [DIV_CNT_W-1:0] DIST_BITS  = 6'd30;

  // Yaw limits, Q12.20 degrees
  localparam logic signed [31:0] SERVO_LIM_Q = 32'sd88080384;  // 84 deg
  localparam logic signed [31:0] TILT_LIM_Q  = 32'sd82837504;  // 79 deg

  // Thresholds on 100*|a| (a in Q5.14 g)
  localparam logic [25:0] LED_LO_TH = 26'd540672;   // 0.33 g
  localparam logic [25:0] LED_HI_TH = 26'd2179072;  // 1.33 g
  localparam logic [25:0] DEAD_TH   = 26'd81920;    // 0.05 g
  localparam logic [25:0] VZERO_TH  = 26'd163840;   // 0.1 g

  localparam logic [7:0]  LED_OFF    = 8'd255;
  localparam logic [7:0]  LED_FULL   = 8'd0;
  localparam logic [7:0]  LED_MIN    = 8'd12;
  localparam logic [11:0] PULSE_BASE = 12'd500;

endpackage

FILE: design/isd_in_if.sv
// Input channel: one raw accel-X / gyro-Z sample per transaction.
interface isd_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x_raw;
  logic signed [15:0] gyro_z_raw;

  modport source (output valid, accel_x_raw, gyro_z_raw, input ready);
  modport sink   (input valid, accel_x_raw, gyro_z_raw, output ready);
endinterface

FILE: design/isd_out_if.sv
// Result channel: servo, LED, tilt, yaw, distance and window end per transaction.
interface isd_out_if;
  logic               valid;
  logic               ready;
  logic [11:0]        servo_pulse;
  logic [7:0]         led_level;
  logic               tilt_led;
  logic signed [31:0] yaw_out;
  logic signed [31:0] distance_out;
  logic               window_end;

  modport source (output valid, servo_pulse, led_level, tilt_led, yaw_out, distance_out,
                  window_end, input ready);
  modport sink   (input valid, servo_pulse, led_level, tilt_led, yaw_out, distance_out,
                  window_end, output ready);
endinterface

FILE: design/isd_sdiv.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module isd_sdiv (
  input  logic             clk,
  input  logic             rst_n,
  input  isd_pkg::div_req_t req,
  output isd_pkg::div_rsp_t rsp
);

  logic                          busy_r;
  logic                          done_r;
  logic [isd_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [isd_pkg::DIV_DSR_W-1:0] rem_r;
  logic [isd_pkg::DIV_DSR_W-1:0] dsr_r;
  logic [isd_pkg::DIV_W-1:0]     dvd_r;

  logic [isd_pkg::DIV_DSR_W:0]   rem_sh;
  logic [isd_pkg::DIV_DSR_W+1:0] trial;
  logic                          qbit;
  logic [isd_pkg::DIV_DSR_W-1:0] rem_nxt;

  // Shift in next dividend bit, trial subtract
  assign rem_sh  = {rem_r, dvd_r[isd_pkg::DIV_W-1]};
  assign trial   = {1'b0, rem_sh} - {2'b00, dsr_r};
  assign qbit    = ~trial[isd_pkg::DIV_DSR_W+1];
  assign rem_nxt = qbit ? trial[isd_pkg::DIV_DSR_W-1:0] : rem_sh[isd_pkg::DIV_DSR_W-1:0];

  // Quotient bits enter at the bottom of the dividend register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.nbits;
        rem_r  <= '0;
        dsr_r  <= req.divisor;
        dvd_r  <= req.dividend;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        dvd_r <= {dvd_r[isd_pkg::DIV_W-2:0], qbit};
        cnt_r <= cnt_r - isd_pkg::DIV_CNT_W'(1);
        if (cnt_r == isd_pkg::DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = dvd_r;

endmodule

FILE: design/imu_sample_to_servo_led_drive_unit.sv
// Top level: yaw integration, servo/tilt/LED mapping and dead reckoning.
// The LED and velocity divisions are skipped when their result is fixed by a
//   threshold. A single bit-serial divider, one quotient bit per cycle, serves
//   all five divisions in turn; a new sample is taken only once the last one
//   has moved into the result register.
// Reset (synchronous, rst_n low): accumulators and window count cleared,
//   registers back to defaults (report period 100), no result pending.
module imu_sample_to_servo_led_drive_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [isd_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [isd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  isd_in_if.sink                           in_chan,
  isd_out_if.source                        out_chan
);

  typedef enum logic [4:0] {
    S_IDLE, S_PREP, S_YDIV, S_YWAIT, S_CLAMP, S_SDIV, S_SWAIT, S_LED, S_LDIV,
    S_LWAIT, S_VMUL, S_VDIV, S_VWAIT, S_DDIV, S_DWAIT, S_DONE
  } state_t;

  state_t state_r;

  // Configuration registers
  logic signed [15:0] accel_off_r;
  logic signed [15:0] gyro_off_r;
  logic [1:0]         accel_rng_r;
  logic [1:0]         gyro_rng_r;
  logic [15:0]        period_r;

  // Accumulated state
  logic signed [31:0] yaw_r;
  logic signed [31:0] vel_r;
  logic signed [31:0] dist_r;
  logic [15:0]        wcnt_r;

  // Per-sample datapath
  logic signed [16:0] da_r;
  logic signed [16:0] dg_r;
  logic signed [19:0] a_r;
  logic [18:0]        abs_a_r;
  logic [15:0]        abs_dg_r;
  logic [25:0]        hund_r;
  logic [20:0]        diff_r;
  logic [28:0]        prod_r;
  logic [27:0]        u_r;
  logic [11:0]        pulse_r;
  logic [7:0]         led_r;

  // Result register
  logic               out_valid_r;
  logic [11:0]        o_pulse_r;
  logic [7:0]         o_led_r;
  logic               o_tilt_r;
  logic signed [31:0] o_yaw_r;
  logic signed [31:0] o_dist_r;
  logic               o_wend_r;

  isd_pkg::div_req_t  div_req;
  isd_pkg::div_rsp_t  div_rsp;

  logic signed [16:0] da_nxt;
  logic signed [16:0] dg_nxt;
  logic signed [19:0] a_nxt;
  logic [19:0]        a_neg;
  logic [16:0]        dg_neg;
  logic [25:0]        hund_nxt;
  logic [28:0]        prod_nxt;
  logic [34:0]        u125;
  logic [28:0]        d255;
  logic [31:0]        abs_v;
  logic signed [31:0] yaw_step;
  logic signed [31:0] vel_step;
  logic signed [31:0] dist_step;
  logic signed [31:0] yaw_c;
  logic signed [31:0] u_nxt;
  logic               tilt;
  logic               wend;
  logic [16:0]        wcnt_inc;
  logic               out_load;

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] x,
                                                 input logic signed [31:0] y);
    logic signed [32:0] s;
    s = {x[31], x} + {y[31], y};
    if (s[32] != s[31]) begin
      sat_add = s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      sat_add = s[31:0];
    end
  endfunction

  isd_sdiv u_sdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Offset removal and range scaling
  assign da_nxt = {in_chan.accel_x_raw[15], in_chan.accel_x_raw} - {accel_off_r[15], accel_off_r};
  assign dg_nxt = {in_chan.gyro_z_raw[15], in_chan.gyro_z_raw} - {gyro_off_r[15], gyro_off_r};
  assign a_nxt  = {{3{da_r[16]}}, da_r} <<< accel_rng_r;
  assign a_neg  = 20'd0 - a_r;
  assign dg_neg = 17'd0 - dg_r;

  // Constant products; the x100 and x981 products are registered, the others feed divider requests directly
  assign hund_nxt = {7'd0, abs_a_r} * 26'd100;
  assign prod_nxt = {10'd0, abs_a_r} * 29'd981;
  assign u125     = {7'd0, u_r} * 35'd125;
  assign d255     = {8'd0, diff_r} * 29'd255;
  assign abs_v    = vel_r[31] ? (32'd0 - vel_r) : vel_r;

  // Signed steps from unsigned quotients, truncated toward zero
  assign yaw_step  = dg_r[16] ? -$signed({5'd0, div_rsp.quot[26:0]})
                              :  $signed({5'd0, div_rsp.quot[26:0]});
  assign vel_step  = a_r[19]  ? -$signed({14'd0, div_rsp.quot[17:0]})
                              :  $signed({14'd0, div_rsp.quot[17:0]});
  assign dist_step = vel_r[31] ? -$signed({7'd0, div_rsp.quot[24:0]})
                               :  $signed({7'd0, div_rsp.quot[24:0]});

  // Servo clamp and offset to unsigned range
  assign yaw_c = (yaw_r > isd_pkg::SERVO_LIM_Q)  ? isd_pkg::SERVO_LIM_Q :
                 (yaw_r < -isd_pkg::SERVO_LIM_Q) ? -isd_pkg::SERVO_LIM_Q : yaw_r;
  assign u_nxt = yaw_c + isd_pkg::SERVO_LIM_Q;

  assign tilt     = (yaw_r > isd_pkg::TILT_LIM_Q) || (yaw_r < -isd_pkg::TILT_LIM_Q);
  assign wcnt_inc = {1'b0, wcnt_r} + 17'd1;
  assign wend     = (wcnt_inc >= {1'b0, period_r});

  // Finished sample moves into the result register once it is free
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_chan.ready);

  // Divider requests, operands left aligned to their bit count
  always_comb begin
    div_req = '0;
    case (state_r)
      S_YDIV: begin
        div_req.start    = 1'b1;
        div_req.nbits    = isd_pkg::YAW_BITS;
        div_req.divisor  = isd_pkg::GYRO_DIV[gyro_rng_r];
        div_req.dividend = {abs_dg_r, 20'd0};
      end
      S_SDIV: begin
        div_req.start    = 1'b1;
        div_req.nbits    = isd_pkg::SERVO_BITS;
        div_req.divisor  = isd_pkg::SERVO_DIV;
        div_req.dividend = {u125[34:19], 20'd0};
      end
      S_LDIV: begin
        div_req.start    = 1'b1;
        div_req.nbits    = isd_pkg::LED_BITS;
        div_req.divisor  = isd_pkg::LED_DIV;
        div_req.dividend = {d255[28:16], 23'd0};
      end
      S_VDIV: begin
        div_req.start    = 1'b1;
        div_req.nbits    = isd_pkg::VEL_BITS;
        div_req.divisor  = isd_pkg::VEL_DIV;
        div_req.dividend = {prod_r[28:2], 9'd0};
      end
      S_DDIV: begin
        div_req.start    = 1'b1;
        div_req.nbits    = isd_pkg::DIST_BITS;
        div_req.divisor  = isd_pkg::DIST_DIV;
        div_req.dividend = {abs_v[31:2], 6'd0};
      end
      default: ;
    endcase
  end

  // Sequencer, accumulators, configuration and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      accel_off_r <= '0;
      gyro_off_r  <= '0;
      accel_rng_r <= '0;
      gyro_rng_r  <= '0;
      period_r    <= isd_pkg::REPORT_PERIOD_RST;
      yaw_r       <= '0;
      vel_r       <= '0;
      dist_r      <= '0;
      wcnt_r      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          isd_pkg::CFG_ACCEL_OFFSET:  accel_off_r <= cfg_wdata;
          isd_pkg::CFG_GYRO_OFFSET:   gyro_off_r  <= cfg_wdata;
          isd_pkg::CFG_ACCEL_RANGE:   accel_rng_r <= cfg_wdata[1:0];
          isd_pkg::CFG_GYRO_RANGE:    gyro_rng_r  <= cfg_wdata[1:0];
          isd_pkg::CFG_REPORT_PERIOD: period_r    <= cfg_wdata;
          default: ;
        endcase
      end

      // Result valid: set on load, cleared on an accepted transaction
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_chan.valid) begin
            da_r    <= da_nxt;
            dg_r    <= dg_nxt;
            state_r <= S_PREP;
          end
        end
        S_PREP: begin
          a_r      <= a_nxt;
          abs_dg_r <= dg_r[16] ? dg_neg[15:0] : dg_r[15:0];
          state_r  <= S_YDIV;
        end
        S_YDIV: begin
          abs_a_r <= a_r[19] ? a_neg[18:0] : a_r[18:0];
          state_r <= S_YWAIT;
        end
        S_YWAIT: begin
          hund_r <= hund_nxt;
          if (div_rsp.done) begin
            yaw_r   <= sat_add(yaw_r, yaw_step);
            state_r <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          u_r     <= u_nxt[27:0];
          state_r <= S_SDIV;
        end
        S_SDIV: begin
          diff_r  <= 21'(hund_r - isd_pkg::LED_LO_TH);
          state_r <= S_SWAIT;
        end
        S_SWAIT: begin
          if (div_rsp.done) begin
            pulse_r <= isd_pkg::PULSE_BASE + {1'b0, div_rsp.quot[10:0]};
            state_r <= S_LED;
          end
        end
        // LED: fixed levels outside the ramp, divide inside it
        S_LED: begin
          if (hund_r < isd_pkg::LED_LO_TH) begin
            led_r   <= isd_pkg::LED_OFF;
            state_r <= S_VMUL;
          end else if (hund_r > isd_pkg::LED_HI_TH) begin
            led_r   <= isd_pkg::LED_FULL;
            state_r <= S_VMUL;
          end else begin
            state_r <= S_LDIV;
          end
        end
        S_LDIV: begin
          state_r <= S_LWAIT;
        end
        S_LWAIT: begin
          if (div_rsp.done) begin
            led_r   <= (div_rsp.quot[7:0] < isd_pkg::LED_MIN) ? isd_pkg::LED_MIN
                                                              : div_rsp.quot[7:0];
            state_r <= S_VMUL;
          end
        end
        // Velocity step only outside the dead band
        S_VMUL: begin
          prod_r  <= prod_nxt;
          state_r <= (hund_r >= isd_pkg::DEAD_TH) ? S_VDIV : S_DDIV;
        end
        S_VDIV: begin
          state_r <= S_VWAIT;
        end
        S_VWAIT: begin
          if (div_rsp.done) begin
            vel_r   <= sat_add(vel_r, vel_step);
            state_r <= S_DDIV;
          end
        end
        S_DDIV: begin
          state_r <= S_DWAIT;
        end
        S_DWAIT: begin
          if (div_rsp.done) begin
            dist_r  <= sat_add(dist_r, dist_step);
            state_r <= S_DONE;
          end
        end
        // Load result once the result register is free; count the window and close it at its end
        S_DONE: begin
          if (out_load) begin
            o_pulse_r   <= pulse_r;
            o_led_r     <= led_r;
            o_tilt_r    <= tilt;
            o_yaw_r     <= yaw_r;
            o_dist_r    <= dist_r;
            o_wend_r    <= wend;
            if (hund_r < isd_pkg::VZERO_TH) begin
              vel_r <= '0;
            end
            if (wend) begin
              dist_r <= '0;
              wcnt_r <= '0;
            end else begin
              wcnt_r <= wcnt_inc[15:0];
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_chan.ready         = (state_r == S_IDLE);
  assign out_chan.valid        = out_valid_r;
  assign out_chan.servo_pulse  = o_pulse_r;
  assign out_chan.led_level    = o_led_r;
  assign out_chan.tilt_led     = o_tilt_r;
  assign out_chan.yaw_out      = o_yaw_r;
  assign out_chan.distance_out = o_dist_r;
  assign out_chan.window_end   = o_wend_r;

endmodule

FILE: design/isd_chk.sv
// Port-level checker for the drive unit, attached by bind.
module isd_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [11:0]        servo_pulse,
  input logic [7:0]         led_level,
  input logic               tilt_led,
  input logic signed [31:0] yaw_out,
  input logic signed [31:0] distance_out,
  input logic               window_end
);

  // A stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(servo_pulse) && $stable(led_level) &&
      $stable(tilt_led) && $stable(yaw_out) && $stable(distance_out) && $stable(window_end))
    else $error("result payload changed while stalled");

  // Servo pulse stays within the mapped span
  a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> servo_pulse >= 12'd500 && servo_pulse <= 12'd2500)
    else $error("servo pulse out of range");

  // LED ramp bottoms out at 12; only full-on goes lower
  a_led: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> led_level == 8'd0 || led_level >= 8'd12)
    else $error("LED level below ramp floor");

  // Tilt means yaw beyond 79 deg, so the pulse sits near an end of its span
  a_tilt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && tilt_led |-> servo_pulse >= 12'd2440 || servo_pulse <= 12'd559)
    else $error("tilt flag disagrees with servo pulse");

endmodule

bind imu_sample_to_servo_led_drive_unit isd_chk u_isd_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .servo_pulse  (out_chan.servo_pulse),
  .led_level    (out_chan.led_level),
  .tilt_led     (out_chan.tilt_led),
  .yaw_out      (out_chan.yaw_out),
  .distance_out (out_chan.distance_out),
  .window_end   (out_chan.window_end)
);
